FILE: rtl/mvma_pkg.sv
// ----------------------------------------------------------------------------
// mvma_pkg
// Shared types and codes for the matrix-vector multiply-accumulate block.
// ----------------------------------------------------------------------------
package mvma_pkg;
	localparam logic [1:0] KIND_MAT   = 2'd0;
	localparam logic [1:0] KIND_X     = 2'd1;
	localparam logic [1:0] KIND_Y     = 2'd2;
	localparam logic [1:0] KIND_START = 2'd3;

	localparam logic [2:0] REG_TRANSPOSE = 3'd0;
	localparam logic [2:0] REG_ROWS      = 3'd1;
	localparam logic [2:0] REG_COLS      = 3'd2;
	localparam logic [2:0] REG_ALPHA     = 3'd3;
	localparam logic [2:0] REG_BETA      = 3'd4;

	localparam int FRAC_BITS = 16;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int CFG_IDX_W = 3;

	// multiplier operand select
	localparam logic [1:0] MUL_AX    = 2'd0;
	localparam logic [1:0] MUL_BETA  = 2'd1;
	localparam logic [1:0] MUL_ALPHA = 2'd2;

	typedef struct packed {
		logic       mul_en;
		logic [1:0] mul_sel;
	} mul_ctl_t;
endpackage

FILE: rtl/mvma_mac.sv
// ----------------------------------------------------------------------------
// mvma_mac
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mvma_mac #(
	parameter int VW = 32
) (
	input  logic                     clk,
	input  mvma_pkg::mul_ctl_t       ctl,
	input  logic signed [VW-1:0]     op_a,
	input  logic signed [VW-1:0]     op_b,
	output logic signed [2*VW-1:0]   prod_q
);
	import mvma_pkg::*;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= op_a * op_b;
		end
	end
endmodule

FILE: rtl/matrix_vector_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply_accumulate
// y = alpha*op(A)*x + beta*y on signed Q16.16 words.
//
// Input channel (in_valid/in_stall): load words (matrix entry, x, y) are
// taken one per cycle. A start word stalls input until every y element of the
// run has been emitted.
// Output channel (out_valid/out_stall): one word per y element in index
// order, last_flag on the final one. A held word is kept while out_stall is
// high; the sequencer waits for it to drain.
// Each y element takes these steps, paced by the single shared multiplier:
// a read, multiply and accumulate step per matrix term, over inner terms
// (inner = columns, or rows when transposed), then the beta product, the
// alpha product, the sum and the emit step. A run covers ylen elements
// after the start; the emit step repeats while the previous word is held.
// Reset clears control and sets configuration to its defaults; the stores are
// undefined until loaded. Configuration must only be written while idle.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_accumulate #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLS    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mvma_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [VALUE_WIDTH-1:0]              cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          kind,
	input  logic [mvma_pkg::IDX_W-1:0]          row_pos,
	input  logic [mvma_pkg::IDX_W-1:0]          col_pos,
	input  logic signed [VALUE_WIDTH-1:0]       sample_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mvma_pkg::IDX_W-1:0]          out_index,
	output logic signed [VALUE_WIDTH-1:0]       out_value,
	output logic                                last_flag
);
	import mvma_pkg::*;

	localparam int VW    = VALUE_WIDTH;
	localparam int VEC   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int VIW   = (VEC > 1) ? $clog2(VEC) : 1;
	localparam int AW    = RW + CW;
	localparam int ACC_W = 2 * VW + 5;
	localparam int SUM_W = 2 * VW - FRAC_BITS + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_ACC   = 3'd3;
	localparam logic [2:0] ST_BETA  = 3'd4;
	localparam logic [2:0] ST_ALPHA = 3'd5;
	localparam logic [2:0] ST_SUM   = 3'd6;
	localparam logic [2:0] ST_EMIT  = 3'd7;

	localparam logic signed [VW-1:0] SMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] SMIN = {1'b1, {(VW-1){1'b0}}};

	logic signed [VW-1:0] mat_mem [MAX_ROWS*MAX_COLS];
	logic signed [VW-1:0] x_mem   [VEC];
	logic signed [VW-1:0] y_mem   [VEC];

	logic                 trans_q;
	logic [CNT_W-1:0]     rows_q, cols_q;
	logic signed [VW-1:0] alpha_q, beta_q;

	logic [2:0]           state_q;
	logic [8:0]           i_q, k_q, ylen_q, inner_q;
	logic signed [VW-1:0] a_q, x_q, y_q, dsat_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [2*VW-1:0]  prod_q;
	logic signed [VW-1:0] op_a, op_b;
	mul_ctl_t             mctl;

	logic [8:0] rows_eff, cols_eff;
	logic [RW-1:0] ra;
	logic [CW-1:0] ca;

	assign in_stall = (state_q != ST_IDLE);

	// clamp counts to the store size
	always_comb begin
		rows_eff = ({4'd0, rows_q} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {4'd0, rows_q};
		cols_eff = ({4'd0, cols_q} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {4'd0, cols_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_q <= 1'b0;
			rows_q  <= CNT_W'(1);
			cols_q  <= CNT_W'(1);
			alpha_q <= VW'(65536);
			beta_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRANSPOSE: trans_q <= cfg_data[0];
				REG_ROWS:      rows_q  <= cfg_data[CNT_W-1:0];
				REG_COLS:      cols_q  <= cfg_data[CNT_W-1:0];
				REG_ALPHA:     alpha_q <= cfg_data;
				REG_BETA:      beta_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// matrix address for the current term
	always_comb begin
		if (trans_q) begin
			ra = RW'(k_q);
			ca = CW'(i_q);
		end else begin
			ra = RW'(i_q);
			ca = CW'(k_q);
		end
	end

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	logic y_we;
	logic signed [VW-1:0] y_res;

	// stores
	always_ff @(posedge clk) begin
		if (in_acc && kind == KIND_MAT && 32'(row_pos) < MAX_ROWS
				&& 32'(col_pos) < MAX_COLS) begin
			mat_mem[AW'(32'(row_pos) * MAX_COLS + 32'(col_pos))] <= sample_value;
		end
		if (in_acc && kind == KIND_X && 32'(row_pos) < VEC) begin
			x_mem[VIW'(row_pos)] <= sample_value;
		end
		if (in_acc && kind == KIND_Y && 32'(row_pos) < VEC) begin
			y_mem[VIW'(row_pos)] <= sample_value;
		end else if (y_we) begin
			y_mem[VIW'(i_q)] <= y_res;
		end
		a_q <= mat_mem[AW'(32'(ra) * MAX_COLS + 32'(ca))];
		x_q <= x_mem[VIW'(k_q)];
		y_q <= y_mem[VIW'(i_q)];
	end

	always_comb begin
		mctl.mul_en  = (state_q == ST_MUL) || (state_q == ST_BETA)
			|| (state_q == ST_ALPHA);
		mctl.mul_sel = MUL_AX;
		op_a = a_q;
		op_b = x_q;
		if (state_q == ST_BETA) begin
			mctl.mul_sel = MUL_BETA;
			op_a = beta_q;
			op_b = y_q;
		end else if (state_q == ST_ALPHA) begin
			mctl.mul_sel = MUL_ALPHA;
			op_a = alpha_q;
			op_b = dsat_q;
		end
	end

	mvma_mac #(.VW(VW)) u_mac (
		.clk    (clk),
		.ctl    (mctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	// dot sum shifted and saturated
	logic signed [ACC_W-FRAC_BITS-1:0] acc_sh;
	logic signed [VW-1:0] dsat_n;
	logic signed [SUM_W-1:0] sum_w;
	assign acc_sh = acc_q[ACC_W-1:FRAC_BITS];
	always_comb begin
		if (acc_sh > (ACC_W-FRAC_BITS)'(SMAX)) dsat_n = SMAX;
		else if (acc_sh < (ACC_W-FRAC_BITS)'(SMIN)) dsat_n = SMIN;
		else dsat_n = VW'(acc_sh);
	end

	// bt held in full width: product >> 16 fits VW+VW-16 bits
	logic signed [2*VW-FRAC_BITS-1:0] at_sh, bt_sh, bt_full_q;
	assign at_sh = prod_q[2*VW-1:FRAC_BITS];
	assign sum_w = SUM_W'(bt_full_q) + SUM_W'(at_sh);
	always_comb begin
		if (sum_w > SUM_W'(SMAX)) y_res = SMAX;
		else if (sum_w < SUM_W'(SMIN)) y_res = SMIN;
		else y_res = VW'(sum_w);
	end
	assign y_we = (state_q == ST_SUM);

	assign bt_sh = prod_q[2*VW-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			i_q       <= '0;
			k_q       <= '0;
			ylen_q    <= '0;
			inner_q   <= '0;
			acc_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && kind == KIND_START && rows_eff != 9'd0
							&& cols_eff != 9'd0) begin
						ylen_q  <= trans_q ? cols_eff : rows_eff;
						inner_q <= trans_q ? rows_eff : cols_eff;
						i_q     <= '0;
						k_q     <= '0;
						acc_q   <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					acc_q <= acc_q + ACC_W'(prod_q);
					if (k_q + 9'd1 == inner_q) begin
						state_q <= ST_BETA;
					end else begin
						k_q     <= k_q + 9'd1;
						state_q <= ST_RD;
					end
				end
				ST_BETA: begin
					dsat_q  <= dsat_n;
					state_q <= ST_ALPHA;
				end
				ST_ALPHA: begin
					bt_full_q <= bt_sh;
					state_q   <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_EMIT;
				end
				// product and bt stay put here, so y_res holds until the word goes out
				ST_EMIT: begin
					if (!out_valid) begin
						out_index <= IDX_W'(i_q);
						out_value <= y_res;
						last_flag <= (i_q + 9'd1 == ylen_q);
						out_valid <= 1'b1;
						k_q       <= '0;
						acc_q     <= '0;
						if (i_q + 9'd1 == ylen_q) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + 9'd1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
